>>> rtl/ring_buffer_deque_assert.svh
// Assertion macros for the ring buffer deque checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef RING_BUFFER_DEQUE_ASSERT_SVH
`define RING_BUFFER_DEQUE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define RBD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbd check failed");

// Next-cycle implication, off during reset.
`define RBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbd check failed");

// Next-cycle implication, active during reset too.
`define RBD_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rbd check failed");

`endif

>>> rtl/rbd_pkg.sv
// Shared types and constants for the ring buffer deque.
// No dependencies; imported by all deque modules except the generic rbd_ram.
`default_nettype none

package rbd_pkg;

  localparam int CAP_W      = 5;
  localparam int COUNT_W    = 5;
  localparam int OP_W       = 3;
  localparam int VAL_W      = 32;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CAP_W-1:0]     CAP_RESET    = 5'd16;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic read;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic cfg_write;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/rbd_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic                   re,
  input  wire logic [AW-1:0]          raddr_a,
  input  wire logic [AW-1:0]          raddr_b,
  output logic      [WIDTH-1:0]       rdata_a,
  output logic      [WIDTH-1:0]       rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rbd_ctrl.sv
// Sequencer for the deque: capture, execute, read back, load result.
// Depends on rbd_pkg.
`default_nettype none

module rbd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire rbd_pkg::stat_t stat,
  output rbd_pkg::cmd_t      cmd
);

  import rbd_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r & ~out_tready;
    unique case (state_r)
      ST_IDLE: begin
        // config restart owns this cycle
        in_tready = ~stat.cfg_write;
        if (in_tvalid && !stat.cfg_write) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/rbd_dp.sv
// Deque datapath: capacity register, indices, count, slot RAM, result register.
// Depends on rbd_pkg and rbd_ram.
`default_nettype none

module rbd_dp #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire rbd_pkg::cmd_t                  cmd,
  output rbd_pkg::stat_t                      stat,
  input  wire logic [rbd_pkg::OP_W-1:0]       in_opcode,
  input  wire logic [rbd_pkg::VAL_W-1:0]      in_value,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [rbd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [rbd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [rbd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic      [rbd_pkg::OUT_DATA_W-1:0] out_data
);

  import rbd_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;

  function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
    logic [CAP_W-1:0] r;
    if (v == '0) begin
      r = CAP_W'(1);
    end else if (int'(v) > DEPTH) begin
      r = CAP_W'(DEPTH);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] front_init(input logic [CAP_W-1:0] cap);
    return (cap == CAP_W'(1)) ? '0 : IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i,
                                               input logic [CAP_W-1:0] cap);
    logic [IDX_W-1:0] r;
    if (SW'(i) + SW'(1) >= SW'(cap)) begin
      r = '0;
    end else begin
      r = i + IDX_W'(1);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] cap);
    logic [IDX_W-1:0] r;
    if (i == '0) begin
      r = IDX_W'(cap - CAP_W'(1));
    end else begin
      r = i - IDX_W'(1);
    end
    return r;
  endfunction

  logic [CAP_W-1:0]      cap_r, cap_nxt;
  logic [IDX_W-1:0]      front_r, front_nxt;
  logic [IDX_W-1:0]      back_r, back_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [OP_W-1:0]       op_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic                  ok_r, ok_nxt;
  logic [OUT_DATA_W-1:0] out_r;

  logic [CAP_W-1:0]      cap_eff;
  logic                  full, empty;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] rdata_a, rdata_b;
  logic [VAL_W-1:0]      front_v, back_v;
  logic                  cfg_hit;
  logic [CAP_W-1:0]      new_cap;

  assign cfg_hit = cfg_psel && cfg_penable && cfg_pwrite &&
                   (cfg_paddr[CFG_ADDR_W-1:2] == REG_CAPACITY);
  assign stat.cfg_write = cfg_hit;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_CAPACITY) ?
                      CFG_DATA_W'(cap_r) : '0;

  assign new_cap = clamp_cap(cfg_pwdata[CAP_W-1:0]);
  assign cap_eff = clamp_cap(cap_r);
  assign full    = (count_r >= cap_eff);
  assign empty   = (count_r == '0);

  always_comb begin
    cap_nxt   = cap_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    count_nxt = count_r;
    ok_nxt    = ok_r;
    ram_we    = 1'b0;
    ram_waddr = front_r;
    if (cmd.exec) begin
      ok_nxt = 1'b0;
      unique case (op_t'(op_r))
        OP_PUSH_FRONT: begin
          if (!full) begin
            ram_waddr = step_down(front_r, cap_eff);
            ram_we    = 1'b1;
            front_nxt = ram_waddr;
            count_nxt = count_r + COUNT_W'(1);
            ok_nxt    = 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (!full) begin
            ram_waddr = step_up(back_r, cap_eff);
            ram_we    = 1'b1;
            back_nxt  = ram_waddr;
            count_nxt = count_r + COUNT_W'(1);
            ok_nxt    = 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (!empty) begin
            front_nxt = step_up(front_r, cap_eff);
            count_nxt = count_r - COUNT_W'(1);
            ok_nxt    = 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (!empty) begin
            back_nxt  = step_down(back_r, cap_eff);
            count_nxt = count_r - COUNT_W'(1);
            ok_nxt    = 1'b1;
          end
        end
        OP_QUERY: begin
          ok_nxt = 1'b1;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
    if (cfg_hit) begin
      cap_nxt   = cfg_pwdata[CAP_W-1:0];
      count_nxt = '0;
      back_nxt  = '0;
      front_nxt = front_init(new_cap);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      front_r <= front_init(clamp_cap(CAP_RESET));
      back_r  <= '0;
      count_r <= '0;
    end else begin
      cap_r   <= cap_nxt;
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;
    if (cmd.capture) begin
      op_r  <= in_opcode;
      val_r <= DATA_WIDTH'(in_value);
    end
    if (cmd.load_out) begin
      out_r <= {1'b0, empty, count_r, back_v, front_v, ok_r};
    end
  end

  // occupied slots were always written since restart; empty reads as zero
  assign front_v = empty ? '0 : VAL_W'(rdata_a);
  assign back_v  = empty ? '0 : VAL_W'(rdata_b);

  rbd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (val_r),
    .re      (cmd.read),
    .raddr_a (front_r),
    .raddr_b (back_r),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign out_data = out_r;

endmodule

`default_nettype wire

>>> rtl/ring_buffer_deque.sv
// Channel  Dir  Handshake              Payload
// in       in   in_tvalid/in_tready    tuser opcode, tdata entry_value
// out      out  out_tvalid/out_tready  tdata op_ok..is_empty
// cfg      in   APB psel/penable       capacity_in_use at byte address 0
//
// Each request passes through capture (the accepting step), update and slot
// write, slot RAM read at front/back, and result load. A new request is taken
// only once the last has loaded its result, set by the write-then-read order
// on the slot RAM.
// Synchronous active-low reset; no clearing pass, empty slots read as zero.
// A result waits in the output register; the next request is taken meanwhile
// and the sequencer holds at result load until the register is free.
//
// Top level of the ring buffer deque; depends on rbd_pkg, rbd_ctrl, rbd_dp.
`default_nettype none

module ring_buffer_deque #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [rbd_pkg::VAL_W-1:0]      in_tdata,  // [31:0] entry_value
  input  wire logic [rbd_pkg::OP_W-1:0]       in_tuser,  // [2:0] opcode
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [0] op_ok, [32:1] front_value, [64:33] back_value, [69:65] entry_count,
  // [70] is_empty, [71] zero
  output logic      [rbd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [rbd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [rbd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [rbd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                cfg_pready
);

  import rbd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_pready = 1'b1;

  rbd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rbd_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_opcode   (in_tuser),
    .in_value    (in_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .out_data    (out_tdata)
  );

endmodule

`default_nettype wire

>>> rtl/rbd_checker.sv
// Port-level checks for the ring buffer deque, bound to the top level.
// Depends on rbd_pkg and ring_buffer_deque_assert.svh.
`default_nettype none

`include "ring_buffer_deque_assert.svh"

module rbd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [rbd_pkg::OUT_DATA_W-1:0] out_tdata
);

  import rbd_pkg::*;

  logic in_req;
  assign in_req = in_tvalid && in_tready;

  // stalled result holds
  `RBD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // one request in flight: no accept right after an accept
  `RBD_ASSERT_NEXT(a_busy_after_req, in_req, !in_tready)
  // empty deque shows zero front and back
  `RBD_ASSERT_NOW(a_empty_zero, out_tvalid && out_tdata[70],
                  (out_tdata[32:1] == '0) && (out_tdata[64:33] == '0))
  // reset drops any pending result
  `RBD_ASSERT_ALWAYS(a_reset_clear, !rst_n, !out_tvalid)

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (.*);

`default_nettype wire

>>> dv/rbd_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the ring buffer deque: tracks accepted requests and
// register writes, predicts each result and compares it. Depends on rbd_pkg.
module rbd_result_checker
  import rbd_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [VAL_W-1:0]      in_tdata,
  input  logic [OP_W-1:0]       in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [CFG_DATA_W-1:0] cfg_prdata,
  input  logic                  cfg_pready,
  output int                    fail_count,
  output int                    pending,
  output int                    results_checked,
  output int                    refused_pushes,
  output int                    empty_pops
);

  localparam int IDX_W = $clog2(DEPTH);

  typedef struct packed {
    logic               ok;
    logic [VAL_W-1:0]   front;
    logic [VAL_W-1:0]   back;
    logic [COUNT_W-1:0] cnt;
    logic               empty;
  } deque_view_t;

  deque_view_t        expected_views[$];
  logic [VAL_W-1:0]   slot_mem[DEPTH];
  logic [CAP_W-1:0]   cap_reg;
  logic [CAP_W-1:0]   cap_used;
  logic [IDX_W-1:0]   head_idx;
  logic [IDX_W-1:0]   tail_idx;
  logic [COUNT_W-1:0] held;

  function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
    if (v == '0) return CAP_W'(1);
    if (v > DEPTH) return CAP_W'(DEPTH);
    return v;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_up(input logic [IDX_W-1:0] i);
    if (CAP_W'(i) + CAP_W'(1) >= cap_used) return '0;
    return i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_down(input logic [IDX_W-1:0] i);
    if (i == '0) return IDX_W'(cap_used - CAP_W'(1));
    return i - IDX_W'(1);
  endfunction

  task automatic start_over();
    for (int k = 0; k < DEPTH; k++) slot_mem[k] = '0;
    cap_used = clamp_cap(cap_reg);
    held     = '0;
    head_idx = (cap_used == CAP_W'(1)) ? '0 : IDX_W'(1);
    tail_idx = '0;
  endtask

  task automatic flag(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] MISMATCH %0s", $realtime, msg);
  endtask

  task automatic apply_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val);
    deque_view_t      v;
    logic [IDX_W-1:0] pos;
    logic             full;
    full = (held >= cap_used);
    v    = '0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          refused_pushes++;
        end else if (op == OP_PUSH_FRONT) begin
          pos = wrap_down(head_idx);
          slot_mem[pos] = val;
          head_idx = pos;
          held = held + 1'b1;
          v.ok = 1'b1;
        end else begin
          pos = wrap_up(tail_idx);
          slot_mem[pos] = val;
          tail_idx = pos;
          held = held + 1'b1;
          v.ok = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (held == '0) begin
          empty_pops++;
        end else begin
          slot_mem[head_idx] = '0;
          head_idx = wrap_up(head_idx);
          held = held - 1'b1;
          v.ok = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (held == '0) begin
          empty_pops++;
        end else begin
          slot_mem[tail_idx] = '0;
          tail_idx = wrap_down(tail_idx);
          held = held - 1'b1;
          v.ok = 1'b1;
        end
      end
      OP_QUERY: v.ok = 1'b1;
      default: ;
    endcase
    v.front = (held != '0) ? slot_mem[head_idx] : '0;
    v.back  = (held != '0) ? slot_mem[tail_idx] : '0;
    v.cnt   = held;
    v.empty = (held == '0);
    expected_views.push_back(v);
    pending++;
  endtask

  task automatic cmp_field(input string name, input int idx, input logic [VAL_W-1:0] exp_v,
                           input logic [VAL_W-1:0] act_v);
    if (exp_v !== act_v)
      flag($sformatf("result %0d %0s: expected %h got %h", idx, name, exp_v, act_v));
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] d);
    deque_view_t e;
    if (expected_views.size() == 0) begin
      flag($sformatf("result with no request pending: %h", d));
      return;
    end
    e = expected_views.pop_front();
    pending--;
    cmp_field("op_ok", results_checked, VAL_W'(e.ok), VAL_W'(d[0]));
    cmp_field("front_value", results_checked, e.front, d[32:1]);
    cmp_field("back_value", results_checked, e.back, d[64:33]);
    cmp_field("entry_count", results_checked, VAL_W'(e.cnt), VAL_W'(d[69:65]));
    cmp_field("is_empty", results_checked, VAL_W'(e.empty), VAL_W'(d[70]));
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cap_reg = CAP_RESET;
      start_over();
      expected_views.delete();
      pending = 0;
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (in_tvalid && in_tready) apply_op(in_tuser, in_tdata);
      if (cfg_psel && cfg_penable && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1:2] == REG_CAPACITY) begin
        if (cfg_pwrite) begin
          cap_reg = cfg_pwdata[CAP_W-1:0];
          start_over();
        end else if (cfg_prdata !== CFG_DATA_W'(cap_reg)) begin
          flag($sformatf("capacity readback: expected %h got %h",
                         CFG_DATA_W'(cap_reg), cfg_prdata));
        end
      end
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Testbench top for the ring buffer deque: clock, reset, request and
// register stimulus, verdict. Depends on rbd_pkg and rbd_result_checker.
module tb;
  import rbd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE      = 10;
  localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_QUERY + 3'd1;

  logic                  clk   = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [VAL_W-1:0]      in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int pending;
  int results_checked;
  int refused_pushes;
  int empty_pops;
  int cycle_count = 0;
  int req_count   = 0;
  int cfg_writes  = 0;
  bit tx_idle_en  = 1'b1;
  bit rx_idle_en  = 1'b1;
  bit rx_hold_req = 1'b0;

  ring_buffer_deque dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  rbd_result_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .refused_pushes (refused_pushes),
    .empty_pops     (empty_pops)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("ring_buffer_deque verification failed");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready  = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic send_req(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = val;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    req_count++;
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_xfer(input bit wr, input logic [CFG_DATA_W-1:0] d);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = {REG_CAPACITY, 2'b00};
    cfg_pwdata  = d;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // upper bits of the write data are junk the register must drop
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_xfer(1'b1, {27'($urandom), cap});
    cfg_writes++;
    cfg_xfer(1'b0, '0);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VAL_W'($urandom);
  endfunction

  task automatic run_phase(input int n, input int push_pct);
    int               r;
    logic [OP_W-1:0]  op;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 4)
        op = OP_W'(OP_UNUSED_LO + $urandom_range(0, 2));
      else if (r < 10)
        op = OP_QUERY;
      else if ($urandom_range(0, 99) < push_pct)
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      else
        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      send_req(op, pick_value());
    end
  endtask

  initial begin
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_QUERY;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset capacity: empty peeks, empty pops, unknown opcodes, extreme words
    cfg_xfer(1'b0, '0);
    send_req(OP_QUERY, '1);
    send_req(OP_POP_FRONT, '1);
    send_req(OP_POP_BACK, '0);
    send_req(OP_UNUSED_LO, '1);
    send_req(OP_W'(OP_UNUSED_LO + 3'd1), 32'h1234_5678);
    send_req('1, '1);
    send_req(OP_PUSH_FRONT, '1);
    send_req(OP_PUSH_BACK, '0);
    send_req(OP_PUSH_BACK, 32'h8000_0001);
    send_req(OP_QUERY, '0);
    send_req(OP_POP_BACK, '1);
    send_req(OP_POP_FRONT, '1);
    send_req(OP_POP_FRONT, '1);

    // zero capacity runs as one slot: full after a single push
    set_capacity('0);
    send_req(OP_PUSH_BACK, 32'hA5A5_5A5A);
    send_req(OP_PUSH_FRONT, 32'h5A5A_A5A5);
    send_req(OP_QUERY, '0);
    send_req(OP_POP_FRONT, '0);
    send_req(OP_POP_BACK, '0);
    send_req(OP_PUSH_FRONT, '1);
    send_req(OP_POP_BACK, '0);

    set_capacity(CAP_W'(16));
    run_phase(60, 75);
    run_phase(40, 25);
    set_capacity(CAP_W'(1));
    run_phase(40, 50);
    run_phase(25, 75);
    set_capacity(CAP_W'(2));
    run_phase(60, 50);

    // over-range capacity clamps to full depth; stall the result side meanwhile
    set_capacity('1);
    rx_hold_req = 1'b1;
    run_phase(80, 75);
    set_capacity(CAP_W'(17));
    run_phase(50, 25);
    set_capacity(CAP_W'($urandom_range(3, 15)));
    run_phase(50, 50);
    run_phase(40, 75);
    run_phase(30, 25);
    set_capacity(CAP_W'($urandom_range(0, 31)));
    run_phase(60, 50);

    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_capacity(CAP_W'(16));
    run_phase(60, 70);
    run_phase(85, 30);

    wait_drained();
    $display("%0d requests over %0d capacity writes, %0d results checked",
             req_count, cfg_writes, results_checked);
    $display("%0d pushes refused when full, %0d pops on an empty deque",
             refused_pushes, empty_pops);
    if (fail_count == 0 && pending == 0) begin
      $display("ring_buffer_deque verification clean");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, pending);
      $display("ring_buffer_deque verification failed");
    end
    $finish;
  end

endmodule
